FILE: design/vfm_pkg.sv
// Shared types, constants and face tables for the voxel face mesher.
// Used by vfm_front, vfm_queue, vfm_back and the top level.
package vfm_pkg;

  localparam int QUEUE_DEPTH = 4;

  localparam int NUM_FACES = 6;
  localparam int CODE_W    = 8;
  localparam int POS_W     = 6;
  localparam int LPOS_W    = 5;

  localparam logic [23:0] COLOR_KEEP = 24'hfefefe;
  localparam logic [3:0]  CORNER_OFS = 4'd15;
  localparam logic [7:0]  THR_RESET  = 8'd100;
  localparam logic [8:0]  MH_RESET   = 9'd64;

  // configuration register indexes
  typedef enum logic {
    CFG_DAMAGE_THR = 1'b0,
    CFG_MAP_HEIGHT = 1'b1
  } cfg_idx_e;

  // per face: normal n, start offset s, in-plane u and v (x, y, z)
  localparam int FACE_N [NUM_FACES][3] = '{
    '{0, 0, 1}, '{0, 0, -1}, '{-1, 0, 0}, '{1, 0, 0}, '{0, -1, 0}, '{0, 1, 0}};
  localparam int FACE_S [NUM_FACES][3] = '{
    '{1, 0, 1}, '{0, 0, 0}, '{0, 1, 0}, '{1, 0, 0}, '{0, 0, 0}, '{1, 1, 0}};
  localparam int FACE_U [NUM_FACES][3] = '{
    '{-1, 0, 0}, '{1, 0, 0}, '{0, 0, 1}, '{0, 0, 1}, '{0, 0, 1}, '{0, 0, 1}};
  localparam int FACE_V [NUM_FACES][3] = '{
    '{0, 1, 0}, '{0, 1, 0}, '{0, -1, 0}, '{0, 1, 0}, '{1, 0, 0}, '{-1, 0, 0}};
  localparam logic [7:0] FACE_SHADE [NUM_FACES] = '{
    8'd0, 8'd220, 8'd0, 8'd0, 8'd255, 8'd0};

  // occlusion code bit b samples a + SU[b]*u + SV[b]*v
  localparam int OCC_SU [CODE_W] = '{-1, 1, 0, 0, -1, -1, 1, 1};
  localparam int OCC_SV [CODE_W] = '{0, 0, -1, 1, 1, -1, 1, -1};

  // one classified cell on its way from front to back
  typedef struct packed {
    logic                                start;
    logic [2:0][LPOS_W-1:0]              lpos;   // [0] x, [1] y, [2] z
    logic [NUM_FACES-1:0]                faces;  // exposed faces, bit = face_dir
    logic [NUM_FACES-1:0][CODE_W-1:0]    code;
    logic [23:0]                         rgb;
  } vfm_entry_t;

  // neighbourhood bit index of offset (dx, dy, dz), each in -1..1
  function automatic logic [4:0] nb_idx(input int dx, input int dy, input int dz);
    int i;
    i = (dz + 1) * 9 + (dy + 1) * 3 + (dx + 1);
    return 5'(i);
  endfunction

endpackage

FILE: design/vfm_front.sv
// Front end: configuration registers and per-cell classification.
// Applies height overrides, finds exposed faces, occlusion codes and color.
// Depends on vfm_pkg.
module vfm_front import vfm_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic              cfg_index_i,
  input  logic [8:0]        cfg_data_i,
  input  logic              start_i,
  input  logic [LPOS_W-1:0] local_x_i,
  input  logic [LPOS_W-1:0] local_y_i,
  input  logic [LPOS_W-1:0] local_z_i,
  input  logic [7:0]        world_z_i,
  input  logic [26:0]       nb_mask_i,
  input  logic [31:0]       cell_color_i,
  output vfm_entry_t        entry_o
);

  logic [7:0] thr_q;
  logic [8:0] mh_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q <= THR_RESET;
      mh_q  <= MH_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_DAMAGE_THR: thr_q <= cfg_data_i[7:0];
        CFG_MAP_HEIGHT: mh_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  logic [26:0] sol;
  logic [2:0]  layer_solid;
  logic        below_floor;
  logic [8:0]  h_lo, h_mid, h_hi;

  // per z layer: below floor reads empty, at or above map height reads solid
  always_comb begin
    h_mid = {1'b0, world_z_i};
    h_lo  = h_mid - 9'd1;
    h_hi  = h_mid + 9'd1;
    below_floor    = (world_z_i == 8'd0);
    layer_solid[0] = h_lo  >= mh_q;
    layer_solid[1] = h_mid >= mh_q;
    layer_solid[2] = h_hi  >= mh_q;
    for (int l = 0; l < 3; l++) begin
      for (int j = 0; j < 9; j++) begin
        if (l == 0 && below_floor) sol[l*9+j] = 1'b0;
        else if (layer_solid[l])   sol[l*9+j] = 1'b1;
        else                       sol[l*9+j] = nb_mask_i[l*9+j];
      end
    end
  end

  logic centre;

  always_comb begin
    int dx, dy, dz;
    centre = sol[nb_idx(0, 0, 0)];
    entry_o.start   = start_i;
    entry_o.lpos[0] = local_x_i;
    entry_o.lpos[1] = local_y_i;
    entry_o.lpos[2] = local_z_i;
    for (int f = 0; f < NUM_FACES; f++) begin
      entry_o.faces[f] = centre &
                         !sol[nb_idx(FACE_N[f][0], FACE_N[f][1], FACE_N[f][2])];
      for (int b = 0; b < CODE_W; b++) begin
        // offsets stay within the 3x3x3 neighbourhood for every face
        dx = FACE_N[f][0] + OCC_SU[b] * FACE_U[f][0] + OCC_SV[b] * FACE_V[f][0];
        dy = FACE_N[f][1] + OCC_SU[b] * FACE_U[f][1] + OCC_SV[b] * FACE_V[f][1];
        dz = FACE_N[f][2] + OCC_SU[b] * FACE_U[f][2] + OCC_SV[b] * FACE_V[f][2];
        entry_o.code[f][b] = sol[nb_idx(dx, dy, dz)];
      end
    end
    if (cell_color_i[31:24] < thr_q) begin
      entry_o.rgb = (cell_color_i[23:0] & COLOR_KEEP) >> 1;
    end else begin
      entry_o.rgb = cell_color_i[23:0];
    end
  end

endmodule

FILE: design/vfm_queue.sv
// Short first-word-fall-through queue of classified cells.
// Decouples front and back; depends on vfm_pkg.
module vfm_queue import vfm_pkg::*; #(
  parameter int DEPTH = QUEUE_DEPTH
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push_i,
  input  vfm_entry_t wdata_i,
  output logic       full_o,
  input  logic       pop_i,
  output logic       valid_o,
  output vfm_entry_t rdata_o
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  vfm_entry_t    mem_q [DEPTH];
  logic [AW-1:0] wptr_q, wptr_d, rptr_q, rptr_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic          do_push, do_pop;

  assign full_o  = (cnt_q == CW'(DEPTH));
  assign valid_o = (cnt_q != '0);
  assign rdata_o = mem_q[rptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    cnt_d  = cnt_q;
    if (do_push) wptr_d = (wptr_q == AW'(DEPTH - 1)) ? '0 : wptr_q + AW'(1);
    if (do_pop)  rptr_d = (rptr_q == AW'(DEPTH - 1)) ? '0 : rptr_q + AW'(1);
    if (do_push && !do_pop)      cnt_d = cnt_q + CW'(1);
    else if (do_pop && !do_push) cnt_d = cnt_q - CW'(1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wptr_q] <= wdata_i;
  end

  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CW'(DEPTH))
    else $error("queue count beyond depth");

  a_ptr_track: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == '0 || full_o) |-> (wptr_q == rptr_q))
    else $error("queue pointers disagree with count");

  a_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (full_o && !do_pop) |=> full_o)
    else $error("full queue lost an entry without a pop");

endmodule

FILE: design/vfm_back.sv
// Back end: walks the exposed faces of one cell, four vertices per face,
// into a registered output stage. Holds the running vertex counter.
// Depends on vfm_pkg.
module vfm_back import vfm_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        q_valid_i,
  input  vfm_entry_t  q_data_i,
  output logic        q_pop_o,
  output logic        m_valid_o,
  input  logic        m_ready_i,
  output logic [87:0] m_data_o,
  output logic        m_last_o
);

  vfm_entry_t           cur_q, cur_d;
  logic                 busy_q, busy_d;
  logic [NUM_FACES-1:0] rem_q, rem_d;
  logic [1:0]           corner_q, corner_d;
  logic [15:0]          vcnt_q, vcnt_d;

  logic                 mv_q, mv_d;
  logic                 last_q, last_d;
  logic [84:0]          vtx_q, vtx_d;

  logic [2:0]           face;
  logic [NUM_FACES-1:0] rem_next;
  logic                 emit, done, load;
  logic [2:0][POS_W-1:0] pos;
  logic                 cu, cv;
  logic [7:0]           occ_u, occ_v, code;

  // lowest pending face goes first, matching the fixed face order
  always_comb begin
    face = '0;
    for (int f = NUM_FACES - 1; f >= 0; f--) begin
      if (rem_q[f]) face = 3'(f);
    end
  end

  always_comb begin
    cu = corner_q[0];
    cv = corner_q[1];
    for (int c = 0; c < 3; c++) begin
      pos[c] = {1'b0, cur_q.lpos[c]} + POS_W'(FACE_S[face][c]) +
               (cu ? POS_W'(FACE_U[face][c]) : '0) +
               (cv ? POS_W'(FACE_V[face][c]) : '0);
    end
    code  = cur_q.code[face];
    occ_u = {code[3:0], (cu ? CORNER_OFS : 4'd0)};
    occ_v = {code[7:4], (cv ? CORNER_OFS : 4'd0)};
  end

  always_comb begin
    emit     = busy_q && (!mv_q || m_ready_i);
    rem_next = rem_q & ~(NUM_FACES'(1) << face);
    done     = emit && (corner_q == 2'd3) && (rem_next == '0);
    load     = q_valid_i && (!busy_q || done);

    cur_d    = cur_q;
    busy_d   = busy_q;
    rem_d    = rem_q;
    corner_d = corner_q;
    vcnt_d   = vcnt_q;
    mv_d     = mv_q;
    last_d   = last_q;
    vtx_d    = vtx_q;

    if (m_ready_i) mv_d = 1'b0;

    if (emit) begin
      mv_d     = 1'b1;
      last_d   = done;
      vtx_d    = {vcnt_q, occ_v, occ_u, FACE_SHADE[face], cur_q.rgb, face,
                  pos[2], pos[1], pos[0]};
      vcnt_d   = vcnt_q + 16'd1;
      corner_d = corner_q + 2'd1;
      if (corner_q == 2'd3) rem_d = rem_next;
      if (done) busy_d = 1'b0;
    end

    // a cell with no exposed face only clears the counter, if flagged
    if (load) begin
      cur_d    = q_data_i;
      rem_d    = q_data_i.faces;
      busy_d   = (q_data_i.faces != '0);
      corner_d = '0;
      if (q_data_i.start) vcnt_d = '0;
    end
  end

  assign q_pop_o   = load;
  assign m_valid_o = mv_q;
  assign m_last_o  = last_q;
  assign m_data_o  = {3'b000, vtx_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q   <= 1'b0;
      rem_q    <= '0;
      corner_q <= '0;
      vcnt_q   <= '0;
      mv_q     <= 1'b0;
      last_q   <= 1'b0;
    end else begin
      busy_q   <= busy_d;
      rem_q    <= rem_d;
      corner_q <= corner_d;
      vcnt_q   <= vcnt_d;
      mv_q     <= mv_d;
      last_q   <= last_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q <= cur_d;
    vtx_q <= vtx_d;
  end

  a_busy_faces: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> (rem_q != '0))
    else $error("busy with no pending face");

  a_last_corner: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mv_q && last_q) |-> (vtx_q[56:53] == CORNER_OFS && vtx_q[64:61] == CORNER_OFS))
    else $error("last vertex is not the far corner");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mv_q && !m_ready_i) |=> (mv_q && $stable(vtx_q)))
    else $error("stalled vertex changed");

endmodule

FILE: design/voxel_face_mesher_with_occlusion_unit.sv
// Voxel face mesher with per-vertex ambient occlusion: top level.
// Instantiates vfm_front, vfm_queue and vfm_back; depends on vfm_pkg.
//
// One cell is taken per cycle while the cell queue has room. A solid cell
// with n exposed faces then occupies the back end while it emits 4*n vertices
// (one vertex per cycle through the output register while the receiver is
// ready); a cell with no exposed face is popped without emitting a vertex.
// Sustained rate is set by that vertex loop. Configuration writes are always
// accepted (cfg_ready_o is high) and must be issued while the block is idle.
module voxel_face_mesher_with_occlusion_unit import vfm_pkg::*; #(
  parameter int QDEPTH = QUEUE_DEPTH
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration write channel
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic        cfg_index_i,
  input  logic [8:0]  cfg_data_i,
  // cell stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // local_x[4:0], local_y[9:5], local_z[14:10], world_z[22:15],
  // neighbour_mask[49:23], cell_color[81:50], zero pad [87:82]
  input  logic [87:0] s_axis_tdata,
  // start_of_chunk[0]
  input  logic        s_axis_tuser,
  // vertex stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // pos_x[5:0], pos_y[11:6], pos_z[17:12], face_dir[20:18], rgb[44:21],
  // shade[52:45], occl_u[60:53], occl_v[68:61], vertex_number[84:69], pad
  output logic [87:0] m_axis_tdata,
  output logic        m_axis_tlast
);

  vfm_entry_t fe_entry, q_entry;
  logic       q_full, q_valid, q_pop;

  assign cfg_ready_o   = 1'b1;
  assign s_axis_tready = !q_full;

  vfm_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_valid_i),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .start_i      (s_axis_tuser),
    .local_x_i    (s_axis_tdata[4:0]),
    .local_y_i    (s_axis_tdata[9:5]),
    .local_z_i    (s_axis_tdata[14:10]),
    .world_z_i    (s_axis_tdata[22:15]),
    .nb_mask_i    (s_axis_tdata[49:23]),
    .cell_color_i (s_axis_tdata[81:50]),
    .entry_o      (fe_entry)
  );

  vfm_queue #(.DEPTH(QDEPTH)) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (s_axis_tvalid),
    .wdata_i (fe_entry),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .rdata_o (q_entry)
  );

  vfm_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .q_valid_i (q_valid),
    .q_data_i  (q_entry),
    .q_pop_o   (q_pop),
    .m_valid_o (m_axis_tvalid),
    .m_ready_i (m_axis_tready),
    .m_data_o  (m_axis_tdata),
    .m_last_o  (m_axis_tlast)
  );

endmodule

FILE: verif/tb_voxel_face_mesher_with_occlusion_unit.sv
// Testbench for voxel_face_mesher_with_occlusion_unit: directed and random voxel cells
// are checked vertex by vertex against an in-bench face/occlusion predictor.
// Depends on vfm_pkg (config register indexes and reset values) and the design top level.
module tb_voxel_face_mesher_with_occlusion_unit;
  import vfm_pkg::*;

  localparam int NUM_DIRS    = 6;
  localparam int CENTRE_BIT  = 13;
  localparam int SETTLE      = 32;
  localparam int STALL_LIMIT = 3000;
  localparam int HOLD_CYCLES = 400;
  localparam int RAND_CELLS  = 75;
  localparam int MAX_PRINTS  = 30;

  localparam logic [23:0] HALF_KEEP  = 24'hfefefe;
  localparam logic [7:0]  CORNER     = 8'd15;
  localparam logic [7:0]  SHADE_DOWN = 8'd220;
  localparam logic [7:0]  SHADE_FRNT = 8'd255;
  localparam logic [26:0] ALL_SOLID  = 27'h7ffffff;

  typedef enum logic [2:0] {DIR_PZ, DIR_NZ, DIR_NX, DIR_PX, DIR_NY, DIR_PY} face_dir_e;

  // per face: normal, quad origin, in-plane u and v steps (x, y, z)
  localparam int NORMAL [NUM_DIRS][3] = '{
    '{0, 0, 1}, '{0, 0, -1}, '{-1, 0, 0}, '{1, 0, 0}, '{0, -1, 0}, '{0, 1, 0}};
  localparam int ORIGIN [NUM_DIRS][3] = '{
    '{1, 0, 1}, '{0, 0, 0}, '{0, 1, 0}, '{1, 0, 0}, '{0, 0, 0}, '{1, 1, 0}};
  localparam int STEP_U [NUM_DIRS][3] = '{
    '{-1, 0, 0}, '{1, 0, 0}, '{0, 0, 1}, '{0, 0, 1}, '{0, 0, 1}, '{0, 0, 1}};
  localparam int STEP_V [NUM_DIRS][3] = '{
    '{0, 1, 0}, '{0, 1, 0}, '{0, -1, 0}, '{0, 1, 0}, '{1, 0, 0}, '{-1, 0, 0}};
  // occlusion bit b looks at air + DU[b]*u + DV[b]*v
  localparam int OCC_DU [8] = '{-1, 1, 0, 0, -1, -1, 1, 1};
  localparam int OCC_DV [8] = '{0, 0, -1, 1, 1, -1, 1, -1};

  typedef struct {
    bit          start;
    logic [4:0]  lx, ly, lz;
    logic [7:0]  wz;
    logic [26:0] mask;
    logic [31:0] color;
  } cell_t;

  typedef struct {
    logic [5:0]  px, py, pz;
    logic [2:0]  dir;
    logic [23:0] rgb;
    logic [7:0]  shade, ou, ov;
    logic [15:0] num;
    logic        last;
  } vertex_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic        cfg_index_i = CFG_DAMAGE_THR;
  logic [8:0]  cfg_data_i = '0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [87:0] s_axis_tdata = '0;
  logic        s_axis_tuser = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [87:0] m_axis_tdata;
  logic        m_axis_tlast;

  voxel_face_mesher_with_occlusion_unit u_top (.*);

  // predictor state
  logic [7:0]  thr_reg = THR_RESET;
  logic [8:0]  hgt_reg = MH_RESET;
  logic [15:0] vtx_count = '0;

  cell_t   cells_to_send[$];
  vertex_t pending_vertices[$];
  cell_t   held_cell;

  int src_idle_pct = 0;
  int sink_idle_pct = 0;
  int hold_ticket = 0;
  int hold_taken = 0;
  int hold_left = 0;
  int quiet_cycles = 0;
  int err_cnt = 0;
  int cells_sent = 0;
  int vertices_checked = 0;
  int cfg_writes = 0;

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  function automatic int nb_bit(int dx, int dy, int dz);
    return (dz + 1) * 9 + (dy + 1) * 3 + (dx + 1);
  endfunction

  // below ground reads empty, at or above the map top reads solid
  function automatic bit is_solid(logic [26:0] m, logic [7:0] wz, int dx, int dy, int dz);
    int h;
    h = int'(wz) + dz;
    if (h < 0) return 1'b0;
    if (h >= int'(hgt_reg)) return 1'b1;
    return m[nb_bit(dx, dy, dz)];
  endfunction

  function automatic logic [7:0] occlusion_code(logic [26:0] m, logic [7:0] wz, int f);
    logic [7:0] code;
    int b;
    code = '0;
    for (b = 0; b < 8; b++)
      code[b] = is_solid(m, wz,
                         NORMAL[f][0] + OCC_DU[b] * STEP_U[f][0] + OCC_DV[b] * STEP_V[f][0],
                         NORMAL[f][1] + OCC_DU[b] * STEP_U[f][1] + OCC_DV[b] * STEP_V[f][1],
                         NORMAL[f][2] + OCC_DU[b] * STEP_U[f][2] + OCC_DV[b] * STEP_V[f][2]);
    return code;
  endfunction

  // expected vertices of one accepted cell, appended to pending_vertices
  function automatic void mesh_cell(cell_t c);
    vertex_t     batch[$];
    vertex_t     v;
    logic [23:0] rgb;
    logic [7:0]  code;
    int          lp[3];
    int          pos[3];
    int          f, k, a, cu, cv;
    if (c.start) vtx_count = '0;
    if (!is_solid(c.mask, c.wz, 0, 0, 0)) return;
    rgb = c.color[23:0];
    if (c.color[31:24] < thr_reg) rgb = (rgb & HALF_KEEP) >> 1;
    lp[0] = int'(c.lx);
    lp[1] = int'(c.ly);
    lp[2] = int'(c.lz);
    for (f = 0; f < NUM_DIRS; f++) begin
      if (is_solid(c.mask, c.wz, NORMAL[f][0], NORMAL[f][1], NORMAL[f][2])) continue;
      code = occlusion_code(c.mask, c.wz, f);
      for (k = 0; k < 4; k++) begin
        cu = k & 1;
        cv = (k >> 1) & 1;
        for (a = 0; a < 3; a++)
          pos[a] = lp[a] + ORIGIN[f][a] + cu * STEP_U[f][a] + cv * STEP_V[f][a];
        v.px  = 6'(pos[0]);
        v.py  = 6'(pos[1]);
        v.pz  = 6'(pos[2]);
        v.dir = 3'(f);
        v.rgb = rgb;
        case (face_dir_e'(f))
          DIR_NZ:  v.shade = SHADE_DOWN;
          DIR_NY:  v.shade = SHADE_FRNT;
          default: v.shade = '0;
        endcase
        v.ou   = {code[3:0], 4'b0} + (cu != 0 ? CORNER : 8'd0);
        v.ov   = {code[7:4], 4'b0} + (cv != 0 ? CORNER : 8'd0);
        v.num  = vtx_count;
        v.last = 1'b0;
        vtx_count++;
        batch = {batch, v};
      end
    end
    if (batch.size() != 0) batch[batch.size() - 1].last = 1'b1;
    pending_vertices = {pending_vertices, batch};
  endfunction

  task automatic report(string what, logic [31:0] got, logic [31:0] want);
    if (err_cnt < MAX_PRINTS)
      $display("MISMATCH vertex %0d %s: got 0x%0h, expected 0x%0h",
               vertices_checked, what, got, want);
    err_cnt++;
  endtask

  task automatic check_vertex();
    vertex_t w;
    if (pending_vertices.size() == 0) begin
      report("unexpected transfer", m_axis_tdata[31:0], '0);
      return;
    end
    w = pending_vertices.pop_front();
    if (m_axis_tdata[5:0] !== w.px)
      report("pos_x", 32'(m_axis_tdata[5:0]), 32'(w.px));
    if (m_axis_tdata[11:6] !== w.py)
      report("pos_y", 32'(m_axis_tdata[11:6]), 32'(w.py));
    if (m_axis_tdata[17:12] !== w.pz)
      report("pos_z", 32'(m_axis_tdata[17:12]), 32'(w.pz));
    if (m_axis_tdata[20:18] !== w.dir)
      report("face_dir", 32'(m_axis_tdata[20:18]), 32'(w.dir));
    if (m_axis_tdata[44:21] !== w.rgb)
      report("rgb", 32'(m_axis_tdata[44:21]), 32'(w.rgb));
    if (m_axis_tdata[52:45] !== w.shade)
      report("shade", 32'(m_axis_tdata[52:45]), 32'(w.shade));
    if (m_axis_tdata[60:53] !== w.ou)
      report("occl_u", 32'(m_axis_tdata[60:53]), 32'(w.ou));
    if (m_axis_tdata[68:61] !== w.ov)
      report("occl_v", 32'(m_axis_tdata[68:61]), 32'(w.ov));
    if (m_axis_tdata[84:69] !== w.num)
      report("vertex_number", 32'(m_axis_tdata[84:69]), 32'(w.num));
    if (m_axis_tlast !== w.last)
      report("last", 32'(m_axis_tlast), 32'(w.last));
    vertices_checked++;
  endtask

  // cell driver: prediction runs on the transfer edge
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) begin
        mesh_cell(held_cell);
        cells_sent++;
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (cells_to_send.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
          held_cell = cells_to_send.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= {6'd0, held_cell.color, held_cell.mask, held_cell.wz,
                            held_cell.lz, held_cell.ly, held_cell.lx};
          s_axis_tuser  <= held_cell.start;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // vertex monitor and receiver backpressure
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) check_vertex();
      if (hold_ticket != hold_taken) begin
        hold_taken = hold_ticket;
        hold_left  = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= ($urandom_range(99) >= sink_idle_pct);
      end
    end
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid_i && cfg_ready_o))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
  end

  initial begin
    wait (quiet_cycles >= STALL_LIMIT);
    $display("Timeout: no transfer for %0d cycles", STALL_LIMIT);
    $display("Verification failed");
    $finish;
  end

  task automatic add_cell(bit st, int x, int y, int z, int wz, logic [26:0] m,
                          logic [31:0] col);
    cell_t c;
    c.start = st;
    c.lx    = 5'(x);
    c.ly    = 5'(y);
    c.lz    = 5'(z);
    c.wz    = 8'(wz);
    c.mask  = m;
    c.color = col;
    cells_to_send = {cells_to_send, c};
  endtask

  task automatic add_random_cell();
    logic [26:0] m;
    logic [31:0] col;
    int          wz, sel;
    sel = $urandom_range(3);
    case (sel)
      0: m = 27'($urandom() & $urandom() & $urandom());
      1: m = 27'($urandom() | $urandom());
      default: m = 27'($urandom());
    endcase
    // mostly solid centres; the rest keep the random centre bit
    if ($urandom_range(99) < 85) m[CENTRE_BIT] = 1'b1;
    sel = $urandom_range(4);
    case (sel)
      0: wz = $urandom_range(1);
      1: begin
        wz = int'(hgt_reg) - $urandom_range(2);
        if (wz < 0) wz = 0;
        if (wz > 255) wz = 255;
      end
      default: wz = $urandom_range(255);
    endcase
    col = $urandom();
    if ($urandom_range(3) == 0) col[31:24] = thr_reg - 8'($urandom_range(1));
    add_cell($urandom_range(19) == 0, $urandom_range(31), $urandom_range(31),
             $urandom_range(31), wz, m, col);
  endtask

  task automatic write_reg(cfg_idx_e idx, logic [8:0] val);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    if (idx == CFG_DAMAGE_THR) thr_reg = val[7:0];
    else hgt_reg = val;
    cfg_writes++;
  endtask

  // sampled mid-cycle so the driver's updates at the edge have settled
  task automatic wait_idle();
    while (cells_to_send.size() != 0 || s_axis_tvalid || pending_vertices.size() != 0)
      @(negedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  initial begin
    int          thr_set[6];
    int          hgt_set[6];
    int          p, i, f;
    logic [26:0] m;
    thr_set = '{0, 255, 37, 200, 128, 1};
    hgt_set = '{1, 256, 0, 511, 150, 64};

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    src_idle_pct  = 17;
    sink_idle_pct = 86;

    // directed cells at reset settings
    add_cell(1, 0, 0, 0, 10, 27'(1) << CENTRE_BIT, 32'h00123456);   // isolated, damaged
    add_cell(0, 31, 31, 31, 10, ALL_SOLID, 32'hffffffff);            // buried
    m = ALL_SOLID;
    m[nb_bit(1, 0, 0)] = 1'b0;
    add_cell(0, 31, 31, 31, 10, m, 32'h64abcdef);                    // health at threshold
    m = ALL_SOLID;
    m[CENTRE_BIT] = 1'b0;
    add_cell(0, 5, 6, 7, 10, m, 32'h11223344);                       // empty centre
    add_cell(1, 9, 9, 9, 10, '0, 32'h00000000);                      // clear with no output
    for (f = 0; f < NUM_DIRS; f++) begin
      m = ALL_SOLID;
      m[nb_bit(NORMAL[f][0], NORMAL[f][1], NORMAL[f][2])] = 1'b0;
      add_cell(0, 3 * f, 31 - f, 4 * f, 20 + f, m, {8'(99 - f), 24'hffffff});
    end
    add_cell(0, 12, 0, 31, 30, 27'h5555555 | (27'(1) << CENTRE_BIT), 32'hff0000ff);
    add_cell(0, 0, 31, 0, 30, 27'h2aaaaaa | (27'(1) << CENTRE_BIT), 32'h00ffffff);
    add_cell(0, 1, 2, 3, 0, 27'h1ff | (27'(1) << CENTRE_BIT), 32'hc8808080);  // floor
    add_cell(0, 4, 5, 6, 63, 27'(1) << CENTRE_BIT, 32'hff123456);    // under map top
    add_cell(0, 7, 8, 9, 64, '0, 32'hff654321);                       // at map top
    add_cell(0, 31, 0, 31, 255, '0, 32'h80a5a5a5);
    add_cell(0, 16, 16, 16, 62, 27'(1) << CENTRE_BIT, 32'hff000000);
    add_cell(1, 31, 31, 0, 1, 27'h00f2c00, 32'h63fedcba);
    wait_idle();

    for (p = 0; p < 6; p++) begin
      src_idle_pct  = (p < 2) ? 17 : (p < 4) ? 86 : 0;
      sink_idle_pct = (p < 2) ? 86 : (p < 4) ? 17 : 0;
      write_reg(CFG_DAMAGE_THR, 9'(thr_set[p]));
      write_reg(CFG_MAP_HEIGHT, 9'(hgt_set[p]));
      // receiver stalls long enough for the input side to back up
      if (p == 4) hold_ticket++;
      for (i = 0; i < RAND_CELLS; i++) add_random_cell();
      wait_idle();
    end

    $display("Covered %0d cells and %0d vertices over %0d register writes,",
             cells_sent, vertices_checked, cfg_writes);
    $display("including height overrides, damage shading and a long output stall.");
    if (err_cnt == 0) begin
      $display("Verification passed");
    end else begin
      $display("%0d mismatches", err_cnt);
      $display("Verification failed");
    end
    $finish;
  end

endmodule
